>>> sv/rotated_rect_segment_hit_test_macros.svh
// assertion macros for the segment hit test
`ifndef ROTATED_RECT_SEGMENT_HIT_TEST_MACROS_SVH
`define ROTATED_RECT_SEGMENT_HIT_TEST_MACROS_SVH
`define RRSH_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("rrsh check failed");
`define RRSH_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("rrsh check failed");
`endif

>>> sv/rrsh_pkg.sv
// shared types and constants for the segment hit test
`timescale 1ns / 1ps
`default_nettype none
package rrsh_pkg;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TFRAC = 30;
    localparam int TW = 33;
    localparam logic signed [TW-1:0] TONE = TW'(64'sd1 <<< TFRAC);
    localparam logic [2:0] IDX_CX = 3'd0;
    localparam logic [2:0] IDX_CY = 3'd1;
    localparam logic [2:0] IDX_HW = 3'd2;
    localparam logic [2:0] IDX_HH = 3'd3;
    localparam logic [2:0] IDX_COS = 3'd4;
    localparam logic [2:0] IDX_SIN = 3'd5;
    // clip interval state carried down the cell row
    typedef struct packed {
        logic                 alive;
        logic signed [TW-1:0] tmin;
        logic signed [TW-1:0] tmax;
    } clip_t;
endpackage
`default_nettype wire

>>> sv/rrsh_div_cell.sv
// one restoring division step of the clip bound quotient, one bit per cell
`timescale 1ns / 1ps
`default_nettype none
module rrsh_div_cell #(
    parameter int W = 80
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W:0]   rem_in,
    input  wire logic [W-1:0] den_in,
    input  wire logic [31:0]  q_in,
    output logic [W:0]        rem_out,
    output logic [W-1:0]      den_out,
    output logic [31:0]       q_out
);
    logic [W+1:0] sh;
    logic         ge;
    always_comb
    begin
        sh = {rem_in, 1'b0};
        ge = sh >= {2'b0, den_in};
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= ge ? (W+1)'(sh - {2'b0, den_in}) : (W+1)'(sh);
            den_out <= den_in;
            q_out   <= {q_in[30:0], ge};
        end
    end
endmodule
`default_nettype wire

>>> sv/rrsh_side.sv
// one clip side: quotient by a chain of division cells, then bound update
`timescale 1ns / 1ps
`default_nettype none
module rrsh_side #(
    parameter int W = 80
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [W-1:0]  den,
    input  wire logic signed [W-1:0]  num,
    input  rrsh_pkg::clip_t           clip_in,
    output rrsh_pkg::clip_t           clip_out
);
    import rrsh_pkg::*;
    localparam int STEPS = TFRAC + 1;
    logic [W-1:0] n_abs, d_abs;
    logic         neg, zden, npos, sat;
    logic [W:0]   rem [0:STEPS];
    logic [W-1:0] dd [0:STEPS];
    logic [31:0]  qq [0:STEPS];
    logic [STEPS:0] neg_d, zden_d, npos_d, sat_d, dpos_d;
    clip_t        cl_d [0:STEPS];
    logic signed [TW-1:0] t;
    always_comb
    begin
        n_abs = num[W-1] ? W'(-num) : W'(num);
        d_abs = den[W-1] ? W'(-den) : W'(den);
        neg   = num[W-1] ^ den[W-1];
        zden  = den == '0;
        npos  = !num[W-1] && num != '0;
        sat   = {1'b0, n_abs} >= {d_abs, 1'b0};
    end
    // divisor is doubled so the first cell, which also shifts, gives the integer bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem[0]    <= (W+1)'(n_abs);
            dd[0]     <= {d_abs[W-2:0], 1'b0};
            qq[0]     <= '0;
            neg_d[0]  <= neg;
            zden_d[0] <= zden;
            npos_d[0] <= npos;
            sat_d[0]  <= sat;
            dpos_d[0] <= !den[W-1];
            cl_d[0]   <= clip_in;
        end
    end
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        rrsh_div_cell #(.W(W)) u_cell (
            .clk(clk), .en(en), .rem_in(rem[i]),
            .den_in(dd[i]), .q_in(qq[i]),
            .rem_out(rem[i+1]), .den_out(dd[i+1]), .q_out(qq[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_d[i+1]  <= neg_d[i];
                zden_d[i+1] <= zden_d[i];
                npos_d[i+1] <= npos_d[i];
                sat_d[i+1]  <= sat_d[i];
                dpos_d[i+1] <= dpos_d[i];
                cl_d[i+1]   <= cl_d[i];
            end
        end
    end
    always_comb
    begin
        t = sat_d[STEPS] ? (TONE <<< 1) : TW'({1'b0, qq[STEPS]});
        if (neg_d[STEPS])
        begin
            t = -t;
        end
        clip_out = cl_d[STEPS];
        if (!zden_d[STEPS])
        begin
            if (dpos_d[STEPS])
            begin
                if (t > clip_out.tmax) clip_out.alive = 1'b0;
                else if (t > clip_out.tmin) clip_out.tmin = t;
            end
            else
            begin
                if (t < clip_out.tmin) clip_out.alive = 1'b0;
                else if (t < clip_out.tmax) clip_out.tmax = t;
            end
        end
        else if (npos_d[STEPS])
        begin
            clip_out.alive = 1'b0;
        end
        if (!cl_d[STEPS].alive)
        begin
            clip_out = cl_d[STEPS];
        end
    end
endmodule
`default_nettype wire

>>> sv/rotated_rect_segment_hit_test.sv
// rotated rectangle segment hit test, top level
// throughput: one item per cycle unless in_stall is high
// each of the four clip sides is an operand stage and 31 division cells
// the output register is skid-buffered, so input is taken while a result waits, until the skid slot fills
// reset clears valid flags and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_rect_segment_hit_test_macros.svh"
module rotated_rect_segment_hit_test (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    segment_hits,
    output logic                    start_inside,
    output logic                    end_inside
);
    import rrsh_pkg::*;
    localparam int LW = 52;
    localparam int W = 56;
    localparam int SIDE_LAT = TFRAC + 2;
    localparam int LAT = 3 + 4 * SIDE_LAT;
    logic signed [31:0] cx_reg, cy_reg;
    logic [30:0]        hw_reg, hh_reg;
    logic signed [15:0] cos_reg, sin_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0; cy_reg <= '0; hw_reg <= '0; hh_reg <= '0;
            cos_reg <= 16'sd16384; sin_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                IDX_CX:  cx_reg <= cfg_data;
                IDX_CY:  cy_reg <= cfg_data;
                IDX_HW:  hw_reg <= cfg_data[30:0];
                IDX_HH:  hh_reg <= cfg_data[30:0];
                IDX_COS: cos_reg <= cfg_data[15:0];
                IDX_SIN: sin_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end
    // stall whole pipe while the skid slot is full
    logic adv, skid_full_reg;
    logic [LAT:0] v_reg;
    assign adv = !skid_full_reg;
    assign in_stall = !adv;
    logic acc;
    assign acc = in_valid && !in_stall;
    // front stages: offsets, then rotation products, then rotated coordinates
    logic signed [32:0] d_reg [0:3];
    logic signed [49:0] m_reg [0:7];
    logic signed [LW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [LW-1:0] hws, hhs;
    assign hws = LW'({1'b0, hw_reg}) <<< TRIG_FRAC_BITS;
    assign hhs = LW'({1'b0, hh_reg}) <<< TRIG_FRAC_BITS;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= 33'(start_x) - 33'(cx_reg);
            d_reg[1] <= 33'(start_y) - 33'(cy_reg);
            d_reg[2] <= 33'(end_x) - 33'(cx_reg);
            d_reg[3] <= 33'(end_y) - 33'(cy_reg);
            for (int k = 0; k < 2; k++)
            begin
                m_reg[4*k]   <= 50'(d_reg[2*k] * cos_reg);
                m_reg[4*k+1] <= 50'(d_reg[2*k+1] * sin_reg);
                m_reg[4*k+2] <= 50'(d_reg[2*k+1] * cos_reg);
                m_reg[4*k+3] <= 50'(d_reg[2*k] * sin_reg);
            end
            sx_reg <= LW'(m_reg[0]) + LW'(m_reg[1]);
            sy_reg <= LW'(m_reg[2]) - LW'(m_reg[3]);
            ex_reg <= LW'(m_reg[4]) + LW'(m_reg[5]);
            ey_reg <= LW'(m_reg[6]) - LW'(m_reg[7]);
        end
    end
    logic s_in, e_in, degen;
    logic signed [W-1:0] dxw, dyw;
    logic signed [W-1:0] den_a [0:3];
    logic signed [W-1:0] num_a [0:3];
    logic signed [W-1:0] sxw, syw, hwv, hhv;
    always_comb
    begin
        sxw = W'(sx_reg); syw = W'(sy_reg); hwv = W'(hws); hhv = W'(hhs);
        s_in = sx_reg >= -hws && sx_reg <= hws && sy_reg >= -hhs && sy_reg <= hhs;
        e_in = ex_reg >= -hws && ex_reg <= hws && ey_reg >= -hhs && ey_reg <= hhs;
        dxw = W'(ex_reg) - sxw;
        dyw = W'(ey_reg) - syw;
        degen = dxw == '0 && dyw == '0;
        den_a[0] = dxw;  num_a[0] = -hwv - sxw;
        den_a[1] = -dxw; num_a[1] = sxw - hwv;
        den_a[2] = dyw;  num_a[2] = -hhv - syw;
        den_a[3] = -dyw; num_a[3] = syw - hhv;
    end
    // clip operands ride along to the side that needs them
    logic signed [W-1:0] dp_reg [0:3][0:3*SIDE_LAT];
    logic signed [W-1:0] np_reg [0:3][0:3*SIDE_LAT];
    logic [2:0] flag_reg [0:4*SIDE_LAT];
    clip_t cl [0:4];
    clip_t cl_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl_reg <= '{alive: 1'b1, tmin: '0, tmax: TONE};
            flag_reg[0] <= {degen, s_in, e_in};
            for (int j = 1; j <= 4*SIDE_LAT; j++) flag_reg[j] <= flag_reg[j-1];
            for (int s = 0; s < 4; s++)
            begin
                dp_reg[s][0] <= den_a[s];
                np_reg[s][0] <= num_a[s];
                for (int j = 1; j <= 3*SIDE_LAT; j++)
                begin
                    dp_reg[s][j] <= dp_reg[s][j-1];
                    np_reg[s][j] <= np_reg[s][j-1];
                end
            end
        end
    end
    assign cl[0] = cl_reg;
    for (genvar s = 0; s < 4; s++)
    begin : g_side
        rrsh_side #(.W(W)) u_side (
            .clk(clk), .en(adv),
            .den(dp_reg[s][s*SIDE_LAT]), .num(np_reg[s][s*SIDE_LAT]),
            .clip_in(cl[s]), .clip_out(cl[s+1])
        );
    end
    logic hit_c;
    logic [2:0] fl;
    assign fl = flag_reg[4*SIDE_LAT];
    assign hit_c = fl[2] ? fl[1] : (cl[4].alive && cl[4].tmin <= cl[4].tmax);
    logic [2:0] res_reg, skid_reg;
    logic       ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0; ov_reg <= 1'b0; skid_full_reg <= 1'b0;
        end
        else
        begin
            if (adv) v_reg <= {v_reg[LAT-1:0], acc};
            if (!ov_reg || !out_stall)
            begin
                ov_reg <= skid_full_reg || (adv && v_reg[LAT]);
                skid_full_reg <= 1'b0;
            end
            else if (adv && v_reg[LAT])
            begin
                skid_full_reg <= 1'b1;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (!ov_reg || !out_stall)
            res_reg <= skid_full_reg ? skid_reg : {hit_c, fl[1], fl[0]};
        else if (adv && v_reg[LAT])
            skid_reg <= {hit_c, fl[1], fl[0]};
    end
    assign out_valid = ov_reg;
    assign {segment_hits, start_inside, end_inside} = res_reg;
    `RRSH_ASSERT_IMPL(a_stall_skid, clk, rst_n, skid_full_reg, in_stall)
    `RRSH_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_full_reg && !out_stall, !skid_full_reg)
    `RRSH_ASSERT_IMPL(a_skid_hold, clk, rst_n, skid_full_reg, out_valid)
endmodule
`default_nettype wire

>>> dv/rotated_rect_segment_hit_test_test.sv
// testbench for the rotated rectangle segment hit test
`timescale 1ns / 1ps

class hit_scoreboard;
    logic signed [31:0] cx, cy, cosv, sinv;
    logic [30:0] hw_r, hh_r;
    bit [2:0] pending[$];
    int errors;

    function new();
        cx = 0; cy = 0; hw_r = 0; hh_r = 0; cosv = 16384; sinv = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            rrsh_pkg::IDX_CX: cx = d;
            rrsh_pkg::IDX_CY: cy = d;
            rrsh_pkg::IDX_HW: hw_r = d[30:0];
            rrsh_pkg::IDX_HH: hh_r = d[30:0];
            rrsh_pkg::IDX_COS: cosv = {{16{d[15]}}, d[15:0]};
            rrsh_pkg::IDX_SIN: sinv = {{16{d[15]}}, d[15:0]};
            default: ;
        endcase
    endfunction

    // truncated Q2.30 quotient, saturated at 2.0
    function longint quotient(longint num, longint den);
        longint unsigned n, d, q, r;
        bit neg;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        if (n >= 2 * d) q = 64'd2 << 30;
        else
        begin
            q = 0; r = n;
            if (r >= d) begin r -= d; q = 1; end
            for (int i = 0; i < 30; i++)
            begin
                r <<= 1; q <<= 1;
                if (r >= d) begin r -= d; q |= 1; end
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function bit clip_side(longint den, longint num, ref longint tlo, ref longint thi);
        longint t;
        if (den == 0) return num <= 0;
        t = quotient(num, den);
        if (den > 0)
        begin
            if (t > thi) return 0;
            if (t > tlo) tlo = t;
        end
        else
        begin
            if (t < tlo) return 0;
            if (t < thi) thi = t;
        end
        return 1;
    endfunction

    function void note_item(logic signed [31:0] ax, ay, bx, by);
        longint sx, sy, ex, ey, dx, dy, hw, hh, tlo, thi, px, py;
        bit si, ei, hit;
        px = longint'(ax) - cx; py = longint'(ay) - cy;
        sx = px * cosv + py * sinv; sy = py * cosv - px * sinv;
        px = longint'(bx) - cx; py = longint'(by) - cy;
        ex = px * cosv + py * sinv; ey = py * cosv - px * sinv;
        hw = longint'(hw_r) << 14; hh = longint'(hh_r) << 14;
        si = sx >= -hw && sx <= hw && sy >= -hh && sy <= hh;
        ei = ex >= -hw && ex <= hw && ey >= -hh && ey <= hh;
        dx = ex - sx; dy = ey - sy;
        if (dx == 0 && dy == 0) hit = si;
        else
        begin
            tlo = 0; thi = 64'sd1 << 30;
            hit = clip_side(dx, -hw - sx, tlo, thi) && clip_side(-dx, sx - hw, tlo, thi)
                && clip_side(dy, -hh - sy, tlo, thi) && clip_side(-dy, sy - hh, tlo, thi)
                && tlo <= thi;
        end
        pending.push_back({hit, si, ei});
    endfunction

    function void check_result(bit hit, bit si, bit ei);
        bit [2:0] e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result item hit=%0b", $time, hit);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e[2] !== hit) begin $display("%0t: segment_hits exp %0b got %0b", $time, e[2], hit); errors++; end
        if (e[1] !== si) begin $display("%0t: start_inside exp %0b got %0b", $time, e[1], si); errors++; end
        if (e[0] !== ei) begin $display("%0t: end_inside exp %0b got %0b", $time, e[0], ei); errors++; end
    endfunction
endclass

module rotated_rect_segment_hit_test_test;
    import rrsh_pkg::*;

    logic clk, rst_n, cfg_we, in_valid, out_stall;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic signed [31:0] start_x, start_y, end_x, end_y;
    wire in_stall, out_valid, segment_hits, start_inside, end_inside;

    hit_scoreboard sb = new();
    int cycles;
    bit hold_off;

    rotated_rect_segment_hit_test dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
        start_x = 0; start_y = 0; end_x = 0; end_y = 0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("rotated_rect_segment_hit_test_test failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_result(segment_hits, start_inside, end_inside);
    end

    // receiver: random stalls, one long hold-off
    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall = 1;
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            out_stall = ($urandom_range(0, 3) == 0) ? 1 : 0;
            if (out_stall) repeat ($urandom_range(0, 11)) @(negedge clk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_we = 1; cfg_index = idx; cfg_data = d;
        sb.set_reg(idx, d);
        @(negedge clk) cfg_we = 0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic send_segment(logic [31:0] ax, ay, bx, by, bit gaps);
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
        in_valid = 1; start_x = ax; start_y = ay; end_x = bx; end_y = by;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(ax, ay, bx, by);
        @(negedge clk);
    endtask

    function automatic logic [31:0] near_coord(logic signed [31:0] c, logic [30:0] h);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return c + h;
            2: return c - h;
            default: return c + $signed($urandom_range(0, 2 * h + 4) - h - 2);
        endcase
    endfunction

    task automatic random_phase(int n, bit gaps);
        logic [31:0] ax, ay;
        for (int i = 0; i < n; i++)
        begin
            ax = near_coord(sb.cx, sb.hw_r + sb.hh_r);
            ay = near_coord(sb.cy, sb.hw_r + sb.hh_r);
            if ($urandom_range(0, 9) == 0)
                send_segment(ax, ay, ax, ay, gaps);
            else
                send_segment(ax, ay, near_coord(sb.cx, sb.hw_r + sb.hh_r),
                             near_coord(sb.cy, sb.hw_r + sb.hh_r), gaps);
        end
        in_valid = 0;
    endtask

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        // directed: reset registers give a point box at the origin
        send_segment(0, 0, 0, 0, 0);
        send_segment(32'h8000_0000, 0, 32'h7fff_ffff, 0, 0);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_segment(5, 0, 5, 0, 0);
        in_valid = 0;
        wait_drained();
        write_reg(IDX_HW, 32'h0001_0000);
        write_reg(IDX_HH, 32'h0002_0000);
        send_segment(32'hfffe_0000, 0, 32'h0002_0000, 0, 0);
        send_segment(32'h0001_0000, 32'hfff0_0000, 32'h0001_0000, 32'h0010_0000, 0);
        send_segment(32'h0001_0001, 32'hfff0_0000, 32'h0001_0001, 32'h0010_0000, 0);
        send_segment(32'h0005_0000, 0, 32'h0003_0000, 0, 0);
        send_segment(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0);
        send_segment(32'hfffd_0000, 32'hfffd_0000, 32'h0003_0000, 32'h0003_0000, 0);
        send_segment(32'h0002_0000, 32'h0003_0000, 32'h0003_0000, 32'h0002_0000, 0);
        in_valid = 0;
        wait_drained();
        // 45 degrees, far centre, extreme registers
        write_reg(IDX_CX, 32'h8000_0000);
        write_reg(IDX_CY, 32'h7fff_ffff);
        write_reg(IDX_HW, 32'h7fff_ffff);
        write_reg(IDX_HH, 32'h7fff_ffff);
        write_reg(IDX_COS, 32'h0000_2d41);
        write_reg(IDX_SIN, 32'h0000_2d41);
        send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
        in_valid = 0;
        wait_drained();
        write_reg(IDX_COS, 32'h0000_c000);
        write_reg(IDX_SIN, 32'h0000_7fff);
        write_reg(3'd7, 32'hffff_ffff);
        send_segment(0, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
        in_valid = 0;
        wait_drained();
        // random phases over several settings
        for (int p = 0; p < 6; p++)
        begin
            write_reg(IDX_CX, (p == 5) ? $urandom : $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000);
            write_reg(IDX_CY, (p == 5) ? $urandom : $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000);
            write_reg(IDX_HW, (p == 0) ? 0 : $urandom_range(0, 32'h003f_ffff));
            write_reg(IDX_HH, (p == 1) ? 0 : $urandom_range(0, 32'h003f_ffff));
            case (p)
                2: begin write_reg(IDX_COS, 0); write_reg(IDX_SIN, 32'h0000_c000); end
                3: begin write_reg(IDX_COS, $urandom); write_reg(IDX_SIN, $urandom); end
                4: begin write_reg(IDX_COS, 32'h0000_8000); write_reg(IDX_SIN, 32'h0000_4000); end
                default: begin write_reg(IDX_COS, 32'h0000_376d); write_reg(IDX_SIN, 32'h0000_2000); end
            endcase
            if (p == 1) hold_off = 1;
            random_phase(150, p != 1);
            // sender pauses until everything is back
            wait_drained();
        end
        if (sb.errors == 0)
            $display("rotated_rect_segment_hit_test_test passed");
        else
            $display("rotated_rect_segment_hit_test_test failed");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/rrsh_pkg.sv
sv/rrsh_div_cell.sv
sv/rrsh_side.sv
sv/rotated_rect_segment_hit_test.sv
dv/rotated_rect_segment_hit_test_test.sv
